/* sv/pva_pkg.sv */
package pva_pkg;

  localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
  localparam logic [1:0] FUNC_ACTIVITY = 2'd2;

  localparam logic [1:0] CFG_VOICE_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_OSC1_OCTAVE  = 2'd1;
  localparam logic [1:0] CFG_OSC2_OCTAVE  = 2'd2;
  localparam logic [1:0] CFG_KLOK_SETTING = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int RR_W       = 3;

  localparam logic [3:0] VOICE_LIMIT_RST = 4'd8;
  localparam logic [7:0] SEMITONES       = 8'd12;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [7:0] playing_mask;
  } pva_in_t;

  typedef struct packed {
    logic       assigned;
    logic [2:0] assigned_voice;
    logic       voice_gated;
    logic [7:0] pitch_note;
    logic [6:0] velocity_out;
    logic       filter_gate_on;
    logic       filter_gate_off;
    logic [7:0] released_mask;
    logic [1:0] klok_rate;
  } pva_out_t;

  // round-robin fallback: whether the pointer moves and where to
  typedef struct packed {
    logic            advance;
    logic [RR_W-1:0] next;
  } pva_rr_t;

  // octave shift in semitones, two's complement mod 256
  function automatic logic [7:0] octave_offset(logic [2:0] oct);
    logic signed [7:0] s;
    s = {{5{oct[2]}}, oct};
    return 8'(s * $signed(SEMITONES));
  endfunction

endpackage

/* sv/pva_voice_pick.sv */
module pva_voice_pick #(
  parameter int VOICES = 8,
  parameter int VIDX_W = 3,
  parameter int LIM_W  = 4
) (
  input  logic [VOICES-1:0]       gate_i,
  input  logic [VOICES-1:0]       playing_i,
  input  logic [LIM_W-1:0]        limit_i,
  input  logic [pva_pkg::RR_W-1:0] rr_ptr_i,
  output logic [VIDX_W-1:0]       voice_o,
  output pva_pkg::pva_rr_t        rr_o
);
  import pva_pkg::*;

  logic              found_free;
  logic              found_open;
  logic [VIDX_W-1:0] free_idx;
  logic [VIDX_W-1:0] open_idx;
  logic [RR_W-1:0]   ptr_eff;
  logic [RR_W:0]     ptr_inc;

  // highest index wins: later hits overwrite earlier ones
  always_comb begin
    found_free = 1'b0;
    found_open = 1'b0;
    free_idx   = '0;
    open_idx   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (LIM_W'(i) < limit_i) begin
        if (!gate_i[i] && !playing_i[i]) begin
          found_free = 1'b1;
          free_idx   = VIDX_W'(i);
        end
        if (!gate_i[i]) begin
          found_open = 1'b1;
          open_idx   = VIDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    ptr_eff = (int'(rr_ptr_i) >= int'(limit_i)) ? '0 : rr_ptr_i;
    ptr_inc = {1'b0, ptr_eff} + (RR_W+1)'(1);
    rr_o.advance = !found_free && !found_open;
    rr_o.next    = (int'(ptr_inc) == int'(limit_i)) ? '0 : ptr_inc[RR_W-1:0];
    if (found_free) begin
      voice_o = free_idx;
    end else if (found_open) begin
      voice_o = open_idx;
    end else begin
      voice_o = VIDX_W'(ptr_eff);
    end
  end

endmodule

/* sv/poly_voice_allocator_core.sv */
// Voice choice, release match and gate count update all settle in the single combinational
// pass ahead of the output register, which captures each accepted input transaction's result.
// Throughput: one transaction per cycle while a full output register is not stalled.
// Reset: voice state, pointer, gate count and latched clock divide clear to zero,
// voice_limit resets to 8, octave and clock divide registers to zero; no clearing pass.
module poly_voice_allocator_core #(
  parameter int VOICES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pva_pkg::pva_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pva_pkg::pva_out_t               out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pva_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pva_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import pva_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int LIM_W  = $clog2(VOICES + 1);

  logic [6:0]        voice_note_q [VOICES];
  logic [VOICES-1:0] voice_gate_q, voice_gate_d;
  logic [VOICES-1:0] playing_q, playing_d;
  logic [RR_W-1:0]   rr_q, rr_d;
  logic [7:0]        gate_cnt_q, gate_cnt_d;
  logic [1:0]        klok_q, klok_d;

  logic [3:0] voice_limit_q;
  logic [2:0] osc1_oct_q;
  logic [2:0] osc2_oct_q;
  logic [1:0] klok_set_q;

  logic     out_valid_q;
  pva_out_t out_q, res;

  logic                  accept;
  logic [LIM_W-1:0]      limit;
  logic [VIDX_W-1:0]     pick;
  pva_rr_t               rr;
  logic                  is_off, is_on;
  logic                  note_wr;
  logic [VOICES-1:0]     rel;
  logic [7:0]            klok_ofs, n1, n2;
  logic [VOICES+7:0]     pmask_ext;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign limit = (voice_limit_q == 4'd0 || int'(voice_limit_q) > VOICES)
               ? LIM_W'(VOICES) : LIM_W'(voice_limit_q);

  pva_voice_pick #(
    .VOICES (VOICES),
    .VIDX_W (VIDX_W),
    .LIM_W  (LIM_W)
  ) u_pick (
    .gate_i    (voice_gate_q),
    .playing_i (playing_q),
    .limit_i   (limit),
    .rr_ptr_i  (rr_q),
    .voice_o   (pick),
    .rr_o      (rr)
  );

  assign pmask_ext = {{VOICES{1'b0}}, in_data_i.playing_mask};

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      rel[i] = (LIM_W'(i) < limit) && (voice_note_q[i] == in_data_i.note);
    end
  end

  always_comb begin
    is_off = (in_data_i.func == FUNC_NOTE_OFF) ||
             (in_data_i.func == FUNC_NOTE_ON && in_data_i.velocity == 7'd0);
    is_on  = (in_data_i.func == FUNC_NOTE_ON) && !is_off;

    klok_ofs = 8'(klok_set_q) * SEMITONES;
    n1 = {1'b0, in_data_i.note} + octave_offset(osc1_oct_q) + klok_ofs;
    n2 = {1'b0, in_data_i.note} + octave_offset(osc2_oct_q) + klok_ofs;

    voice_gate_d = voice_gate_q;
    playing_d    = playing_q;
    rr_d         = rr_q;
    gate_cnt_d   = gate_cnt_q;
    klok_d       = klok_q;
    note_wr      = 1'b0;
    res          = '0;

    if (is_off) begin
      voice_gate_d        = voice_gate_q & ~rel;
      gate_cnt_d          = gate_cnt_q - 8'd1;
      res.filter_gate_off = (gate_cnt_d == 8'd0);
      res.released_mask   = 8'(rel);
    end else if (is_on) begin
      note_wr            = 1'b1;
      klok_d             = klok_set_q;
      if (rr.advance) begin
        rr_d = rr.next;
      end
      res.assigned       = 1'b1;
      res.assigned_voice = 3'(pick);
      res.pitch_note     = n2;
      // main note out of range: assign the voice but leave it ungated
      if (!n1[7]) begin
        res.velocity_out = in_data_i.velocity;
        if (!voice_gate_q[pick]) begin
          voice_gate_d[pick] = 1'b1;
          res.voice_gated    = 1'b1;
          gate_cnt_d         = gate_cnt_q + 8'd1;
          res.filter_gate_on = (gate_cnt_d == 8'd1);
        end
      end
    end else if (in_data_i.func == FUNC_ACTIVITY) begin
      playing_d = pmask_ext[VOICES-1:0];
    end
    res.klok_rate = klok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_gate_q <= '0;
      playing_q    <= '0;
      rr_q         <= '0;
      gate_cnt_q   <= '0;
      klok_q       <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        voice_note_q[i] <= '0;
      end
    end else begin
      if (accept) begin
        voice_gate_q <= voice_gate_d;
        playing_q    <= playing_d;
        rr_q         <= rr_d;
        gate_cnt_q   <= gate_cnt_d;
        klok_q       <= klok_d;
        if (note_wr) begin
          voice_note_q[pick] <= in_data_i.note;
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_limit_q <= VOICE_LIMIT_RST;
      osc1_oct_q    <= '0;
      osc2_oct_q    <= '0;
      klok_set_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VOICE_LIMIT:  voice_limit_q <= cfg_wdata_i;
        CFG_OSC1_OCTAVE:  osc1_oct_q    <= cfg_wdata_i[2:0];
        CFG_OSC2_OCTAVE:  osc2_oct_q    <= cfg_wdata_i[2:0];
        CFG_KLOK_SETTING: klok_set_q    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/pva_checker.sv */
module pva_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pva_pkg::pva_out_t out_data_o
);
  import pva_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // every accepted transaction shows a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // only a full, stalled output register may push back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output can drain");

  // gate events only come with an assigned voice, release events never do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.voice_gated || out_data_o.filter_gate_on)
      |-> out_data_o.assigned && !out_data_o.filter_gate_off &&
          out_data_o.released_mask == 8'd0)
    else $error("gate event without voice assignment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.filter_gate_on |-> out_data_o.voice_gated)
    else $error("filter gate on without a newly gated voice");

endmodule

bind poly_voice_allocator_core pva_checker u_pva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/poly_voice_allocator_core_tb.sv */
`timescale 1ns / 100ps

module poly_voice_allocator_core_tb;
  import pva_pkg::*;

  localparam int NV = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 300;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  pva_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  pva_out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // shadow of the allocator
  logic [6:0] v_note [NV];
  logic v_gate [NV];
  logic v_playing [NV];
  logic [2:0] rr_ptr;
  logic [7:0] gate_cnt;
  logic [1:0] klok_latched;
  logic [3:0] cfg_limit;
  logic [2:0] cfg_osc1;
  logic [2:0] cfg_osc2;
  logic [1:0] cfg_klok;

  pva_out_t pending_results[$];
  logic [6:0] held_notes[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  poly_voice_allocator_core #(
    .VOICES(NV)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic pva_out_t predict_voice_event(input pva_in_t ev);
    pva_out_t r;
    int lim;
    int pick;
    int n1;
    int n2;
    logic [7:0] a1;
    r = '0;
    lim = (cfg_limit == 4'd0 || cfg_limit > NV) ? NV : int'(cfg_limit);
    if (ev.func == FUNC_NOTE_OFF || (ev.func == FUNC_NOTE_ON && ev.velocity == 7'd0)) begin
      for (int i = 0; i < lim; i++) begin
        if (v_note[i] == ev.note) begin
          v_gate[i] = 1'b0;
          r.released_mask[i] = 1'b1;
        end
      end
      gate_cnt = gate_cnt - 8'd1;
      r.filter_gate_off = (gate_cnt == 8'd0);
    end else if (ev.func == FUNC_NOTE_ON) begin
      pick = -1;
      for (int i = 0; i < lim; i++) begin
        if (!v_playing[i] && !v_gate[i]) pick = i;
      end
      if (pick < 0) begin
        for (int i = 0; i < lim; i++) begin
          if (!v_gate[i]) pick = i;
        end
      end
      // every voice gated: take the round-robin slot, wrap if past the limit
      if (pick < 0) begin
        pick = (int'(rr_ptr) >= lim) ? 0 : int'(rr_ptr);
        rr_ptr = 3'((pick + 1) % lim);
      end
      klok_latched = cfg_klok;
      v_note[pick] = ev.note;
      n1 = int'(ev.note) + 12 * int'($signed(cfg_osc1)) + 12 * int'(klok_latched);
      n2 = int'(ev.note) + 12 * int'($signed(cfg_osc2)) + 12 * int'(klok_latched);
      a1 = 8'(n1);
      r.assigned = 1'b1;
      r.assigned_voice = 3'(pick);
      r.pitch_note = 8'(n2);
      if (a1 < 8'd128) begin
        r.velocity_out = ev.velocity;
        if (!v_gate[pick]) begin
          v_gate[pick] = 1'b1;
          r.voice_gated = 1'b1;
          gate_cnt = gate_cnt + 8'd1;
          r.filter_gate_on = (gate_cnt == 8'd1);
        end
      end
    end else if (ev.func == FUNC_ACTIVITY) begin
      for (int i = 0; i < NV; i++) v_playing[i] = ev.playing_mask[i];
    end
    r.klok_rate = klok_latched;
    return r;
  endfunction

  function automatic pva_in_t make_event(input logic [1:0] func, input logic [6:0] note,
                                         input logic [6:0] vel, input logic [7:0] mask);
    pva_in_t ev;
    ev.func = func;
    ev.note = note;
    ev.velocity = vel;
    ev.playing_mask = mask;
    return ev;
  endfunction

  // mostly matched note-on / note-off pairs over a narrow pitch band, some noise
  function automatic pva_in_t next_voice_event();
    pva_in_t ev;
    logic [23:0] raw;
    int sel;
    int k;
    raw = 24'($urandom);
    ev = raw;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      ev.func = FUNC_NOTE_ON;
      if ($urandom_range(0, 1) == 1) ev.note = 7'($urandom_range(54, 69));
      if (ev.velocity != 7'd0 && held_notes.size() < 16) held_notes.push_back(ev.note);
    end else if (sel < 80 || (sel >= 92 && sel < 96)) begin
      ev.func = (sel < 80) ? FUNC_NOTE_OFF : FUNC_NOTE_ON;
      if (sel >= 92) ev.velocity = 7'd0;
      if (held_notes.size() != 0 && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, held_notes.size() - 1);
        ev.note = held_notes[k];
        held_notes.delete(k);
      end
    end else if (sel < 92) begin
      ev.func = FUNC_ACTIVITY;
    end else begin
      ev.func = FUNC_UNUSED;
    end
    return ev;
  endfunction

  // called just after a falling edge; returns just after a falling edge
  task automatic send_item(input pva_in_t ev);
    while (!no_gaps && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_voice_event(ev));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [3:0] lim, input logic [3:0] o1,
                              input logic [3:0] o2, input logic [3:0] kl);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_VOICE_LIMIT;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_idx_i <= CFG_OSC1_OCTAVE;
    cfg_wdata_i <= o1;
    @(negedge clk_i);
    cfg_idx_i <= CFG_OSC2_OCTAVE;
    cfg_wdata_i <= o2;
    @(negedge clk_i);
    cfg_idx_i <= CFG_KLOK_SETTING;
    cfg_wdata_i <= kl;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_limit = lim;
    cfg_osc1 = o1[2:0];
    cfg_osc2 = o2[2:0];
    cfg_klok = kl[1:0];
  endtask

  task automatic test_allocation_basics();
    send_item(make_event(FUNC_NOTE_ON, 7'd127, 7'd127, 8'h00));
    send_item(make_event(FUNC_NOTE_ON, 7'd0, 7'd1, 8'hFF));
    send_item(make_event(FUNC_ACTIVITY, 7'd0, 7'd0, 8'hFF));
    send_item(make_event(FUNC_NOTE_ON, 7'd60, 7'd64, 8'h00));
    send_item(make_event(FUNC_NOTE_OFF, 7'd127, 7'd0, 8'h00));
    // same note again on a voice already released
    send_item(make_event(FUNC_NOTE_OFF, 7'd127, 7'd127, 8'hFF));
    send_item(make_event(FUNC_NOTE_ON, 7'd0, 7'd0, 8'h00));
    send_item(make_event(FUNC_UNUSED, 7'd127, 7'd127, 8'hFF));
    send_item(make_event(FUNC_ACTIVITY, 7'd127, 7'd127, 8'h00));
    // unmatched note-off drives the gate count below zero
    send_item(make_event(FUNC_NOTE_OFF, 7'd99, 7'd5, 8'h00));
  endtask

  task automatic test_round_robin();
    apply_config(4'd2, 4'd0, 4'd0, 4'd0);
    for (int i = 0; i < 5; i++) begin
      send_item(make_event(FUNC_NOTE_ON, 7'(10 + i), 7'd100, 8'h00));
    end
    // pointer now sits past a one-voice limit
    apply_config(4'd1, 4'd0, 4'd0, 4'd1);
    send_item(make_event(FUNC_NOTE_ON, 7'd15, 7'd100, 8'h00));
    apply_config(4'd0, 4'd0, 4'd0, 4'd2);
    send_item(make_event(FUNC_NOTE_ON, 7'd16, 7'd100, 8'h00));
    apply_config(4'd15, 4'd0, 4'd0, 4'd0);
    send_item(make_event(FUNC_NOTE_ON, 7'd17, 7'd100, 8'h00));
  endtask

  task automatic test_note_range();
    apply_config(4'd8, 4'd3, 4'd5, 4'd3);
    send_item(make_event(FUNC_NOTE_ON, 7'd127, 7'd90, 8'h00));
    apply_config(4'd8, 4'd5, 4'd3, 4'd0);
    send_item(make_event(FUNC_NOTE_ON, 7'd0, 7'd90, 8'h00));
    send_item(make_event(FUNC_NOTE_ON, 7'd100, 7'd90, 8'h00));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_config(4'd1, {1'($urandom), 3'b101}, {1'($urandom), 3'b011}, 4'd0);
        1: apply_config(4'd8, {1'($urandom), 3'b011}, {1'($urandom), 3'b101}, 4'd3);
        2: apply_config(4'd0, 4'd0, 4'd0, 4'($urandom));
        default: apply_config(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
      endcase
      no_gaps = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(next_voice_event());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    apply_config(4'd8, 4'd0, 4'd0, 4'd1);
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) send_item(next_voice_event());
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    for (int i = 0; i < NV; i++) begin
      v_note[i] = '0;
      v_gate[i] = 1'b0;
      v_playing[i] = 1'b0;
    end
    rr_ptr = '0;
    gate_cnt = '0;
    klok_latched = '0;
    cfg_limit = VOICE_LIMIT_RST;
    cfg_osc1 = '0;
    cfg_osc2 = '0;
    cfg_klok = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_allocation_basics();
    test_round_robin();
    test_note_range();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 30);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  pva_out_t exp_r;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, got %h", $time,
                 out_data_o);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("assigned", 8'(exp_r.assigned), 8'(out_data_o.assigned));
        check_field("assigned_voice", 8'(exp_r.assigned_voice), 8'(out_data_o.assigned_voice));
        check_field("voice_gated", 8'(exp_r.voice_gated), 8'(out_data_o.voice_gated));
        check_field("pitch_note", exp_r.pitch_note, out_data_o.pitch_note);
        check_field("velocity_out", 8'(exp_r.velocity_out), 8'(out_data_o.velocity_out));
        check_field("filter_gate_on", 8'(exp_r.filter_gate_on), 8'(out_data_o.filter_gate_on));
        check_field("filter_gate_off", 8'(exp_r.filter_gate_off),
                    8'(out_data_o.filter_gate_off));
        check_field("released_mask", exp_r.released_mask, out_data_o.released_mask);
        check_field("klok_rate", 8'(exp_r.klok_rate), 8'(out_data_o.klok_rate));
      end
    end
  end

  // count cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

/* poly_voice_allocator_core.f */
sv/pva_pkg.sv
sv/pva_voice_pick.sv
sv/poly_voice_allocator_core.sv
sv/pva_checker.sv
tb/sv/poly_voice_allocator_core_tb.sv
